>>> design/cofr_pkg.sv
// shared types and constants for the circle outline and fill rasterizer
`default_nettype none

package cofr_pkg;

    // request kinds carried on the input tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam int COORD_BITS_DEFAULT = 16;

    // field widths of the input and of the circle state
    localparam int CENTER_BITS = 15;
    localparam int RADIUS_BITS = 14;
    localparam int OFFSET_BITS = 16;
    localparam int DECIDE_BITS = 17;
    localparam int S_TDATA_BITS = 48;

    // last index of a step in each mode
    localparam logic [2:0] LAST_OUTLINE_IDX = 3'd7;
    localparam logic [2:0] LAST_FILL_IDX    = 3'd3;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_CNT_BITS = 2;

    // one iteration handed from the front to the back
    typedef struct packed {
        logic signed [CENTER_BITS-1:0] center_x;
        logic signed [CENTER_BITS-1:0] center_y;
        logic signed [OFFSET_BITS-1:0] across;
        logic signed [OFFSET_BITS-1:0] down;
        logic                          fill;
        logic                          circle_end;
    } job_t;

endpackage

`default_nettype wire

>>> design/cofr_front.sv
// front part: takes requests, holds circle state, runs the decision update
`default_nettype none

module cofr_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // center_x[14:0], center_y[29:15], circle_radius[43:30], fill_mode[44]
    input  wire logic [cofr_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,
    // op[0]
    input  wire logic [0:0]                          s_axis_tuser,
    output logic                                     job_valid,
    output cofr_pkg::job_t                           job,
    input  wire logic                                job_ready
);
    import cofr_pkg::*;

    logic signed [CENTER_BITS-1:0] center_x_reg, center_y_reg;
    logic signed [CENTER_BITS-1:0] center_x_next, center_y_next;
    logic [RADIUS_BITS-1:0]        radius_reg, radius_next;
    logic signed [OFFSET_BITS-1:0] across_reg, across_next, down_reg, down_next;
    logic signed [DECIDE_BITS-1:0] decide_reg, decide_next;
    logic                          fill_reg, fill_next;
    logic                          active_reg, active_next;

    logic                          accept;
    logic                          is_start;
    logic [RADIUS_BITS-1:0]        in_radius;
    logic signed [18:0]            d_w, a2, rb2, d_upd;
    logic signed [OFFSET_BITS-1:0] a_upd, b_upd;
    logic                          ends;

    assign s_axis_tready = job_ready;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign is_start  = (s_axis_tuser[0] == OP_START);
    assign in_radius = s_axis_tdata[43:30];

    // three-way decision rule
    always_comb begin
        d_w   = 19'(decide_reg);
        a2    = 19'(across_reg) <<< 1;
        rb2   = (19'($signed({1'b0, radius_reg})) - 19'(down_reg)) <<< 1;
        d_upd = d_w;
        a_upd = across_reg;
        b_upd = down_reg;
        priority if (d_w >= a2) begin
            d_upd = d_w - a2 - 19'sd1;
            a_upd = across_reg + 16'sd1;
        end else if (d_w < rb2) begin
            d_upd = d_w + (19'(down_reg) <<< 1) - 19'sd1;
            b_upd = down_reg - 16'sd1;
        end else begin
            d_upd = d_w + ((19'(down_reg) - 19'(across_reg) - 19'sd1) <<< 1);
            b_upd = down_reg - 16'sd1;
            a_upd = across_reg + 16'sd1;
        end
        ends = (b_upd < a_upd);
    end

    assign job_valid       = accept && !is_start && active_reg;
    assign job.center_x    = center_x_reg;
    assign job.center_y    = center_y_reg;
    assign job.across      = across_reg;
    assign job.down        = down_reg;
    assign job.fill        = fill_reg;
    assign job.circle_end  = ends;

    always_comb begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        radius_next   = radius_reg;
        across_next   = across_reg;
        down_next     = down_reg;
        decide_next   = decide_reg;
        fill_next     = fill_reg;
        active_next   = active_reg;
        if (accept && is_start) begin
            center_x_next = s_axis_tdata[14:0];
            center_y_next = s_axis_tdata[29:15];
            radius_next   = in_radius;
            fill_next     = s_axis_tdata[44];
            across_next   = '0;
            down_next     = $signed({2'b00, in_radius});
            decide_next   = $signed({3'b000, in_radius}) - 17'sd1;
            active_next   = 1'b1;
        end else if (job_valid) begin
            across_next = a_upd;
            down_next   = b_upd;
            decide_next = DECIDE_BITS'(d_upd);
            active_next = !ends;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
            across_reg   <= '0;
            down_reg     <= '0;
            decide_reg   <= '0;
            fill_reg     <= 1'b0;
            active_reg   <= 1'b0;
        end else begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            radius_reg   <= radius_next;
            across_reg   <= across_next;
            down_reg     <= down_next;
            decide_reg   <= decide_next;
            fill_reg     <= fill_next;
            active_reg   <= active_next;
        end
    end

    // a start always leaves a circle running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_start) |=> active_reg)
        else $error("circle not active after start");

endmodule

`default_nettype wire

>>> design/cofr_queue.sv
// short queue of iterations between front and back
`default_nettype none

module cofr_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire cofr_pkg::job_t push_job,
    output logic                has_room,
    output logic                pop_valid,
    output cofr_pkg::job_t      pop_job,
    input  wire logic           pop
);
    import cofr_pkg::*;

    job_t                      slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                      do_push, do_pop;

    assign has_room  = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = slot_reg[rd_ptr_reg];
    assign do_push   = push && has_room;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // front must never push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> has_room)
        else $error("push while queue full");

endmodule

`default_nettype wire

>>> design/cofr_back.sv
// back part: walks one iteration into points or spans, one per cycle unless m_axis_tready stalls the output
`default_nettype none

module cofr_back #(
    parameter int COORD_BITS = cofr_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      job_valid,
    input  wire cofr_pkg::job_t                            job,
    output logic                                           job_pop,
    output logic                                           m_axis_tvalid,
    input  wire logic                                      m_axis_tready,
    // span_start_x, span_end_x, span_row, each COORD_BITS, zero padded
    output logic [((3*COORD_BITS+7)/8)*8-1:0]              m_axis_tdata,
    output logic                                           m_axis_tlast,
    // circle_last[0]
    output logic [0:0]                                     m_axis_tuser
);
    import cofr_pkg::*;

    localparam int TDATA_BITS = ((3*COORD_BITS+7)/8)*8;

    job_t                          cur_reg;
    logic                          busy_reg;
    logic [2:0]                    idx_reg;
    logic                          valid_reg, last_reg, circ_reg;
    logic signed [COORD_BITS-1:0]  sx_reg, ex_reg, row_reg;

    logic                          advance, final_idx, swap, xneg, yneg;
    logic signed [OFFSET_BITS-1:0] u, v;
    logic signed [16:0]            cx17, cy17, pos, neg, rowv, sx, ex;

    assign advance   = busy_reg && (!valid_reg || m_axis_tready);
    assign final_idx = (idx_reg == (cur_reg.fill ? LAST_FILL_IDX : LAST_OUTLINE_IDX));
    assign job_pop   = !busy_reg || (advance && final_idx);

    // pick which offset goes across and which sign applies for this index
    always_comb begin
        if (cur_reg.fill) begin
            swap = (idx_reg == 3'd0) || (idx_reg == 3'd3);
            xneg = 1'b0;
            yneg = idx_reg[1];
        end else begin
            swap = idx_reg[0];
            xneg = idx_reg[1];
            yneg = idx_reg[2];
        end
        u    = swap ? cur_reg.down : cur_reg.across;
        v    = swap ? cur_reg.across : cur_reg.down;
        cx17 = 17'(cur_reg.center_x);
        cy17 = 17'(cur_reg.center_y);
        pos  = cx17 + 17'(u);
        neg  = cx17 - 17'(u);
        rowv = yneg ? (cy17 - 17'(v)) : (cy17 + 17'(v));
        if (cur_reg.fill) begin
            sx = neg;
            ex = pos;
        end else begin
            sx = xneg ? neg : pos;
            ex = sx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (job_pop) begin
                busy_reg <= job_valid;
                idx_reg  <= '0;
                if (job_valid) begin
                    cur_reg <= job;
                end
            end else if (advance) begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (advance) begin
                valid_reg <= 1'b1;
                sx_reg    <= COORD_BITS'(sx);
                ex_reg    <= COORD_BITS'(ex);
                row_reg   <= COORD_BITS'(rowv);
                last_reg  <= final_idx;
                circ_reg  <= final_idx && cur_reg.circle_end;
            end else if (m_axis_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid   = valid_reg;
    assign m_axis_tdata    = TDATA_BITS'({row_reg, ex_reg, sx_reg});
    assign m_axis_tlast    = last_reg;
    assign m_axis_tuser[0] = circ_reg;

    // the end of a circle is always the end of its iteration
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("circle end without step end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cur_reg.fill) |-> (idx_reg <= LAST_FILL_IDX))
        else $error("fill index past last span");

endmodule

`default_nettype wire

>>> design/circle_outline_and_fill_rasterizer.sv
// top level of the circle outline and fill rasterizer
// A start request (tuser op = 0) loads center, radius and mode into registers and
// gives no output; each step request (op = 1) runs one iteration of the circle
// and yields eight outline points or four horizontal spans, one result per cycle
// from the back end while the receiver keeps m_axis_tready high; the single
// result channel sets that rate.
// Up to two steps are queued ahead of the back end, so steps and starts are
// taken back to back while the queue has room and earlier results are still
// draining. tlast marks the last result of an iteration, tuser the last result
// of the circle. A step with no circle running is taken and dropped.
`default_nettype none

module circle_outline_and_fill_rasterizer #(
    parameter int COORD_BITS = cofr_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // center_x[14:0], center_y[29:15], circle_radius[43:30], fill_mode[44]
    input  wire logic [cofr_pkg::S_TDATA_BITS-1:0]       s_axis_tdata,
    // op[0]
    input  wire logic [0:0]                              s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // span_start_x, span_end_x, span_row, each COORD_BITS, zero padded
    output logic [((3*COORD_BITS+7)/8)*8-1:0]            m_axis_tdata,
    output logic                                         m_axis_tlast,
    // circle_last[0]
    output logic [0:0]                                   m_axis_tuser
);
    import cofr_pkg::*;

    logic front_valid, q_room, q_valid, q_pop;
    job_t front_job, q_job;

    cofr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .job_valid     (front_valid),
        .job           (front_job),
        .job_ready     (q_room)
    );

    cofr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_job  (front_job),
        .has_room  (q_room),
        .pop_valid (q_valid),
        .pop_job   (q_job),
        .pop       (q_pop)
    );

    cofr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (q_valid),
        .job           (q_job),
        .job_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the circle outline and fill rasterizer
module testbench;
    import cofr_pkg::*;

    localparam int COORD       = COORD_BITS_DEFAULT;
    localparam int M_BITS      = ((3 * COORD + 7) / 8) * 8;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_TAIL  = 40;
    localparam int RANDOM_REQS = 320;

    typedef struct packed {
        logic signed [COORD-1:0] start_x;
        logic signed [COORD-1:0] end_x;
        logic signed [COORD-1:0] row;
        logic                    step_last;
        logic                    circle_last;
    } span_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata;
    logic [0:0]              s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_BITS-1:0]       m_axis_tdata;
    logic                    m_axis_tlast;
    logic [0:0]              m_axis_tuser;

    // rasterizer state as the predictor sees it
    int  pos_x;
    int  pos_y;
    int  radius;
    int  across;
    int  down;
    int  decision;
    bit  fill_on;
    bit  circle_on;

    span_t expected_spans[$];
    int    error_count;
    int    requests_sent;
    int    spans_checked;
    int    circles_done;
    int    idle_cycles;
    int    ready_hold;
    bit    no_idle;

    circle_outline_and_fill_rasterizer #(
        .COORD_BITS(COORD)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic span_t make_span(int sx, int ex, int row);
        span_t s;
        s.start_x     = COORD'(sx);
        s.end_x       = COORD'(ex);
        s.row         = COORD'(row);
        s.step_last   = 1'b0;
        s.circle_last = 1'b0;
        return s;
    endfunction

    // one accepted request: update the circle state and queue the spans it yields
    function automatic void rasterize_request(logic op, logic signed [CENTER_BITS-1:0] cx,
                                              logic signed [CENTER_BITS-1:0] cy,
                                              logic [RADIUS_BITS-1:0] r, logic fill);
        span_t spans[8];
        int    n;
        int    a;
        int    b;
        int    d;
        if (op == OP_START) begin
            pos_x     = int'(cx);
            pos_y     = int'(cy);
            radius    = int'(r);
            fill_on   = fill;
            across    = 0;
            down      = radius;
            decision  = radius - 1;
            circle_on = 1'b1;
            return;
        end
        if (!circle_on) return;
        a = across;
        b = down;
        d = decision;
        if (fill_on) begin
            spans[0] = make_span(pos_x - b, pos_x + b, pos_y + a);
            spans[1] = make_span(pos_x - a, pos_x + a, pos_y + b);
            spans[2] = make_span(pos_x - a, pos_x + a, pos_y - b);
            spans[3] = make_span(pos_x - b, pos_x + b, pos_y - a);
            n = 4;
        end else begin
            spans[0] = make_span(pos_x + a, pos_x + a, pos_y + b);
            spans[1] = make_span(pos_x + b, pos_x + b, pos_y + a);
            spans[2] = make_span(pos_x - a, pos_x - a, pos_y + b);
            spans[3] = make_span(pos_x - b, pos_x - b, pos_y + a);
            spans[4] = make_span(pos_x + a, pos_x + a, pos_y - b);
            spans[5] = make_span(pos_x + b, pos_x + b, pos_y - a);
            spans[6] = make_span(pos_x - a, pos_x - a, pos_y - b);
            spans[7] = make_span(pos_x - b, pos_x - b, pos_y - a);
            n = 8;
        end
        // andres three-way update
        if (d >= 2 * a) begin
            d = d - (2 * a + 1);
            a = a + 1;
        end else if (d < 2 * (radius - b)) begin
            d = d + 2 * b - 1;
            b = b - 1;
        end else begin
            d = d + 2 * (b - a - 1);
            b = b - 1;
            a = a + 1;
        end
        across   = a;
        down     = b;
        decision = d;
        spans[n-1].step_last = 1'b1;
        if (b < a) begin
            circle_on = 1'b0;
            spans[n-1].circle_last = 1'b1;
            circles_done++;
        end
        for (int k = 0; k < n; k++) expected_spans.push_back(spans[k]);
    endfunction

    function automatic void check_field(string name, logic signed [COORD-1:0] exp_v,
                                        logic signed [COORD-1:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // result checker and receiver stall draw
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_spans.size() == 0) begin
                error_count++;
                $display("%0t unexpected result: expected none, actual %h tlast %b tuser %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                check_field("span_start_x", expected_spans[0].start_x,
                            m_axis_tdata[COORD-1:0]);
                check_field("span_end_x", expected_spans[0].end_x,
                            m_axis_tdata[2*COORD-1:COORD]);
                check_field("span_row", expected_spans[0].row,
                            m_axis_tdata[3*COORD-1:2*COORD]);
                check_field("step_last", COORD'(expected_spans[0].step_last),
                            COORD'(m_axis_tlast));
                check_field("circle_last", COORD'(expected_spans[0].circle_last),
                            COORD'(m_axis_tuser[0]));
                void'(expected_spans.pop_front());
                spans_checked++;
            end
            ready_hold = no_idle ? 0 : $urandom_range(0, 14);
        end
    end

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout at %0t with %0d results outstanding", $time,
                     expected_spans.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(logic op, logic signed [CENTER_BITS-1:0] cx,
                                logic signed [CENTER_BITS-1:0] cy,
                                logic [RADIUS_BITS-1:0] r, logic fill);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, fill, r, cy, cx};
        do @(posedge aclk); while (!s_axis_tready);
        if (op == OP_START || circle_on) requests_sent++;
        rasterize_request(op, cx, cy, r, fill);
    endtask

    task automatic send_step();
        send_request(OP_STEP, CENTER_BITS'($urandom), CENTER_BITS'($urandom),
                     RADIUS_BITS'($urandom), 1'($urandom));
    endtask

    task automatic run_circle(int cx, int cy, int r, bit fill, int max_steps);
        send_request(OP_START, CENTER_BITS'(cx), CENTER_BITS'(cy), RADIUS_BITS'(r), fill);
        for (int i = 0; i < max_steps && circle_on; i++) send_step();
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (expected_spans.size() != 0) @(posedge aclk);
    endtask

    task automatic test_steps_without_circle();
        send_step();
        send_step();
    endtask

    task automatic test_zero_radius();
        run_circle(0, 0, 0, 1'b0, 1);
        send_step();
        run_circle(-16384, 16383, 0, 1'b1, 1);
    endtask

    task automatic test_extremes_and_restart();
        // each start drops the circle before it
        run_circle(0, 0, 5, 1'b0, 2);
        run_circle(16383, 16383, 16383, 1'b1, 2);
        run_circle(-16384, -16384, 16383, 1'b0, 2);
        run_circle(16383, -16384, 3, 1'b0, 10);
        run_circle(-16384, 16383, 2, 1'b1, 10);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_circle(100, -200, 6, 1'b1, 20);
        run_circle(-7, 9, 4, 1'b0, 20);
        no_idle = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        run_circle(-300, 250, 7, 1'b0, 3);
        wait_drained();
        for (int i = 0; i < 20 && circle_on; i++) send_step();
    endtask

    task automatic test_random();
        int kind;
        int r;
        int stop;
        while (requests_sent < RANDOM_REQS) begin
            kind    = $urandom_range(0, 99);
            no_idle = ($urandom_range(0, 4) == 0);
            if (kind < 75) begin
                r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 24);
                run_circle(int'(CENTER_BITS'($urandom)), int'(CENTER_BITS'($urandom)), r,
                           1'($urandom), 100);
                if ($urandom_range(0, 5) == 0) send_step();
            end else if (kind < 85) begin
                // abandoned partway, the next start drops it
                stop = $urandom_range(0, 4);
                run_circle(int'(CENTER_BITS'($urandom)), int'(CENTER_BITS'($urandom)),
                           $urandom_range(0, 16383), 1'($urandom), stop);
            end else if (kind < 93) begin
                send_step();
            end else begin
                run_circle(int'(CENTER_BITS'($urandom)), int'(CENTER_BITS'($urandom)),
                           $urandom_range(0, 12), 1'($urandom), 100);
                wait_drained();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        m_axis_tready = 1'b0;
        ready_hold    = 0;
        no_idle       = 1'b0;
        error_count   = 0;
        requests_sent = 0;
        spans_checked = 0;
        circles_done  = 0;
        idle_cycles   = 0;
        pos_x         = 0;
        pos_y         = 0;
        radius        = 0;
        across        = 0;
        down          = 0;
        decision      = 0;
        fill_on       = 1'b0;
        circle_on     = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_steps_without_circle();
        test_zero_radius();
        test_extremes_and_restart();
        test_back_to_back();
        test_pause_until_drained();
        test_random();

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge aclk);
        $display("%0d requests sent, %0d spans and points checked, %0d circles completed",
                 requests_sent, spans_checked, circles_done);
        $display("outline and fill, zero and full radius, restarts and stray steps exercised");
        if (error_count == 0 && expected_spans.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d errors, %0d results never arrived", error_count,
                     expected_spans.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
